// ===== design/txrd_pkg.sv =====
// Shared types and constants for the table XOR random draw block.
// Used by the front, queue, back and top-level modules; no dependencies.
package txrd_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] STEP_A = 8'd254;
	localparam logic [7:0] STEP_B = 8'd1;
	localparam logic [7:0] STEP_C = 8'd3;
	localparam logic [7:0] STEP_D = 8'd7;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_SEED = 2'd1,
		OP_DRAW = 2'd2
	} op_t;

	typedef struct packed {
		logic            is_draw;
		logic [30:0]     limit;
		logic [3:0][7:0] idx;
		logic [7:0]      addr;
		logic [7:0]      tbyte;
	} txrd_item_t;

endpackage

// ===== design/txrd_front.sv =====
// Front part: accepts input beats, keeps the index and seed counter state,
// and forwards load and draw work to the queue. Depends on txrd_pkg.
module txrd_front import txrd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        q_full,
	output logic        q_push,
	output txrd_item_t  q_item
);

	logic        seed_lock_q;
	logic [8:0]  counter_q;
	logic [7:0]  idx_a_q, idx_b_q, idx_c_q, idx_d_q;
	logic        accept;
	op_t         op;
	logic [31:0] seed;
	logic [8:0]  n;
	logic [7:0]  nl;
	logic [7:0]  seed_a, seed_b, seed_c, seed_d;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign op       = op_t'(s_tuser);
	assign seed     = s_tdata[47:16];
	assign n        = counter_q + 9'd1;
	assign nl       = n[7:0];
	assign seed_a   = seed[8:1] + {nl[6:0], 1'b0} + nl;
	assign seed_b   = nl + {seed[6:0], 1'b0} + seed[7:0];
	assign seed_c   = seed[12:5] + {nl[5:0], 2'b00};
	assign seed_d   = seed[10:3] + n[8:1];

	always_comb begin
		q_push          = accept && (op inside {OP_LOAD, OP_DRAW});
		q_item.is_draw  = (op == OP_DRAW);
		q_item.limit    = s_tdata[78:48];
		q_item.idx      = {idx_d_q, idx_c_q, idx_b_q, idx_a_q};
		q_item.addr     = s_tdata[7:0];
		q_item.tbyte    = s_tdata[15:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_lock_q <= 1'b0;
		end else if (cfg_we) begin
			seed_lock_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			idx_a_q   <= '0;
			idx_b_q   <= '0;
			idx_c_q   <= '0;
			idx_d_q   <= '0;
		end else if (accept) begin
			case (op)
				OP_SEED: begin
					if (!seed_lock_q) begin
						counter_q <= n;
						idx_a_q   <= seed_a;
						idx_b_q   <= seed_b;
						idx_c_q   <= seed_c;
						idx_d_q   <= seed_d;
					end
				end
				OP_DRAW: begin
					idx_a_q <= idx_a_q + STEP_A;
					idx_b_q <= idx_b_q + STEP_B;
					idx_c_q <= idx_c_q + STEP_C;
					idx_d_q <= idx_d_q + STEP_D;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== design/txrd_queue.sv =====
// Short FIFO between the front and back parts.
// Depends on txrd_pkg for the item type.
module txrd_queue import txrd_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  txrd_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output txrd_item_t pop_item
);

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	txrd_item_t    store_q [Depth];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(Depth));
	assign empty    = (count_q == '0);
	assign pop_item = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(Depth))
		else $error("queue count exceeds depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue popped while empty");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue pushed while full");

endmodule

// ===== design/txrd_back.sv =====
// Back part: writes the replicated table on loads, reads four bytes for a
// draw, scales them with one multiplier and holds the result beat. Uses txrd_pkg.
module txrd_back import txrd_pkg::*; #(
	parameter int TableDepth = TABLE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  txrd_item_t  q_item,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata
);

	localparam int AW = $clog2(TableDepth);

	logic [7:0]  tbl_q [4][TableDepth];
	logic [7:0]  rd_s1 [4];
	logic [30:0] limit_s1;
	logic        valid_s1;
	logic        valid_s2;
	logic [30:0] value_s2;
	logic        adv_s2;
	logic [7:0]  r8;
	logic [15:0] r16;
	logic [22:0] mul_a;
	logic [15:0] mul_b;
	logic [38:0] prod;
	logic [30:0] value;

	assign adv_s2   = !valid_s2 || m_tready;
	assign q_pop    = !q_empty && (!valid_s1 || adv_s2);
	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, value_s2};

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			if (q_pop && !q_item.is_draw) begin
				tbl_q[i][q_item.addr[AW-1:0]] <= q_item.tbyte;
			end
			if (q_pop && q_item.is_draw) begin
				rd_s1[i] <= tbl_q[i][q_item.idx[i][AW-1:0]];
			end
		end
		if (q_pop && q_item.is_draw) begin
			limit_s1 <= q_item.limit;
		end
	end

	always_comb begin
		r8  = rd_s1[0] ^ rd_s1[1] ^ rd_s1[2];
		r16 = {rd_s1[2] ^ rd_s1[0] ^ rd_s1[3], r8};
		if (limit_s1[30:8] == '0) begin
			mul_a = {15'd0, limit_s1[7:0]};
			mul_b = {8'd0, r8};
		end else if (limit_s1[30:16] == '0) begin
			mul_a = {7'd0, limit_s1[15:0]};
			mul_b = r16;
		end else begin
			mul_a = limit_s1[30:8];
			mul_b = {8'd0, r8};
		end
		prod = 39'(mul_a) * 39'(mul_b);
		if (limit_s1[30:8] == '0) begin
			value = {23'd0, prod[15:8]};
		end else if (limit_s1[30:16] == '0) begin
			value = {15'd0, prod[31:16]};
		end else begin
			value = {prod[38:16], rd_s1[3]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			value_s2 <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= q_item.is_draw;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	a_draw_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_item.is_draw) |=> valid_s1)
		else $error("popped draw did not reach the read stage");
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !q_item.is_draw) |=> !valid_s1)
		else $error("load beat produced a draw in the read stage");
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(limit_s1)))
		else $error("stalled read stage lost its draw");

endmodule

// ===== design/table_xor_random_draw_top.sv =====
// Top level of the table XOR random draw block.
// Instantiates txrd_front, txrd_queue and txrd_back; uses txrd_pkg.
//
// The block accepts one input beat per clock cycle and sustains that rate
// as long as result beats are taken. Load beats fill the 256-byte table,
// seed beats set the four indices from the seed word and counter unless
// seed_lock is set, and draw beats each give one result beat, in order,
// via the queue, read stage and result register. A four-entry queue sits
// between the front part that keeps the index state and the back part, so
// input beats keep flowing while a result waits. The rate is set by the
// table, held as four copies written together so a draw reads its four bytes
// at once, and by the single 23 by 16 bit multiplier that scales every draw.
module table_xor_random_draw_top import txrd_pkg::*; #(
	parameter int TABLE_DEPTH_P = TABLE_DEPTH,
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,  // seed_lock
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,    // table_address, table_byte, seed_value, limit, zero pad
	input  logic [1:0]  s_tuser,    // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata     // random_value, zero pad
);

	logic       q_full;
	logic       q_push;
	txrd_item_t q_push_item;
	logic       q_pop;
	logic       q_empty;
	txrd_item_t q_pop_item;

	txrd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_push_item)
	);

	txrd_queue #(
		.Depth (QUEUE_DEPTH_P)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_item  (q_pop_item)
	);

	txrd_back #(
		.TableDepth (TABLE_DEPTH_P)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_item   (q_pop_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
